@@ rtl/sbsa_pkg.sv @@
// shared types, constants and helper functions of the superblock slot allocator
// no dependencies
package sbsa_pkg;

    localparam int MAX_SLOTS_DEF = 128;
    localparam int WORD_W        = 32;
    localparam int POS_W         = 5;
    localparam int IDX_W         = 7;
    localparam int CNT_W         = 8;
    localparam int FREE_W        = 7;
    localparam int OFS_W         = 10;
    localparam int SC_W          = 2;
    localparam int LEN_W         = 7;
    localparam int APB_W         = 32;
    localparam int ADDR_W        = 3;

    localparam logic [WORD_W-1:0] WORD_ALL  = 32'hFFFF_FFFF;
    localparam logic [SC_W-1:0]   SC_RST    = 2'd0;
    localparam logic [LEN_W-1:0]  LEN_RST   = 7'd127;
    localparam logic [CNT_W-1:0]  RECIP3    = 8'd171;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_RANGE   = 2'd2,
        ST_ALREADY = 2'd3
    } t_status;

    typedef struct packed {
        logic [SC_W-1:0]  size_class;
        logic [CNT_W-1:0] slot_total;
        logic             load;
        logic [CNT_W-1:0] load_total;
    } t_cfg_bus;

    // control area in 8-byte units
    function automatic logic [2:0] ctl_units(input logic [SC_W-1:0] sc);
        logic [2:0] u;
        unique case (sc)
            2'd0:    u = 3'd3;
            2'd1:    u = 3'd2;
            2'd2:    u = 3'd2;
            default: u = 3'd4;
        endcase
        return u;
    endfunction

    function automatic logic [CNT_W-1:0] slot_count(input logic [SC_W-1:0] sc,
                                                    input logic [LEN_W-1:0] len,
                                                    input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0]   u;
        logic [CNT_W-1:0]   h;
        logic [CNT_W-1:0]   d;
        logic [2*CNT_W-1:0] p;
        logic [CNT_W-1:0]   n;
        u = CNT_W'(len) + CNT_W'(1);
        h = CNT_W'(ctl_units(sc));
        d = u - h;
        p = d * RECIP3;
        unique case (sc)
            2'd0:    n = d;
            2'd1:    n = d >> 1;
            2'd2:    n = CNT_W'(p[2*CNT_W-1:9]);
            default: n = d >> 2;
        endcase
        if (u <= h) begin
            n = '0;
        end
        if (n > cap) begin
            n = cap;
        end
        return n;
    endfunction

    function automatic logic [WORD_W-1:0] word_mask(input logic [CNT_W-1:0] n, input int w);
        logic [CNT_W:0]  nn;
        logic [CNT_W:0]  base;
        logic [CNT_W:0]  diff;
        logic [WORD_W-1:0] m;
        nn   = (CNT_W+1)'(n);
        base = (CNT_W+1)'(w * WORD_W);
        diff = nn - base;
        if (nn >= base + (CNT_W+1)'(WORD_W)) begin
            m = WORD_ALL;
        end else if (nn > base) begin
            m = ~(WORD_ALL >> diff[POS_W-1:0]);
        end else begin
            m = '0;
        end
        return m;
    endfunction

    function automatic logic [OFS_W-1:0] slot_offset(input logic [SC_W-1:0] sc,
                                                     input logic [IDX_W-1:0] idx);
        logic [IDX_W+2:0]  prod;
        logic [IDX_W+6:0]  sum;
        prod = (IDX_W+3)'(idx) * (IDX_W+3)'({1'b0, sc} + 3'd1);
        sum  = ((IDX_W+7)'(prod) << 3) + ((IDX_W+7)'(ctl_units(sc)) << 3);
        return sum[OFS_W-1:0];
    endfunction

endpackage

@@ rtl/sbsa_if.sv @@
// request and response channel interfaces of the superblock slot allocator
// depends on sbsa_pkg
interface sbsa_req_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [sbsa_pkg::IDX_W-1:0]  slot_index;

    modport source (output valid, func, slot_index, input ready);
    modport sink   (input valid, func, slot_index, output ready);
endinterface

interface sbsa_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   status;
    logic [sbsa_pkg::IDX_W-1:0]   granted_index;
    logic [sbsa_pkg::OFS_W-1:0]   byte_offset;
    logic [sbsa_pkg::FREE_W-1:0]  free_left;
    logic                         now_full;
    logic                         now_all_free;
    logic                         first_free_again;

    modport source (output valid, status, granted_index, byte_offset, free_left,
                    now_full, now_all_free, first_free_again, input ready);
    modport sink   (input valid, status, granted_index, byte_offset, free_left,
                    now_full, now_all_free, first_free_again, output ready);
endinterface

@@ rtl/sbsa_cfg.sv @@
// apb configuration registers and slot count of the superblock slot allocator
// depends on sbsa_pkg
module sbsa_cfg #(
    parameter int MAX_SLOTS = sbsa_pkg::MAX_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sbsa_pkg::ADDR_W-1:0]   paddr,
    input  logic [sbsa_pkg::APB_W-1:0]    pwdata,
    output logic [sbsa_pkg::APB_W-1:0]    prdata,
    output logic                          pready,
    output sbsa_pkg::t_cfg_bus            o_cfg
);

    localparam logic REG_SIZE_CLASS = 1'b0;
    localparam logic REG_LENGTH     = 1'b1;
    localparam logic [sbsa_pkg::CNT_W-1:0] CAP = sbsa_pkg::CNT_W'(MAX_SLOTS);

    logic [sbsa_pkg::SC_W-1:0]  r_sc;
    logic [sbsa_pkg::LEN_W-1:0] r_len;
    logic [sbsa_pkg::CNT_W-1:0] r_total;
    logic [sbsa_pkg::SC_W-1:0]  n_sc;
    logic [sbsa_pkg::LEN_W-1:0] n_len;
    logic [sbsa_pkg::CNT_W-1:0] n_total;
    logic                       wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    always_comb begin
        n_sc  = r_sc;
        n_len = r_len;
        if (paddr[2] == REG_LENGTH) begin
            n_len = pwdata[sbsa_pkg::LEN_W-1:0];
        end else begin
            n_sc = pwdata[sbsa_pkg::SC_W-1:0];
        end
        n_total = sbsa_pkg::slot_count(n_sc, n_len, CAP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc    <= sbsa_pkg::SC_RST;
            r_len   <= sbsa_pkg::LEN_RST;
            r_total <= sbsa_pkg::slot_count(sbsa_pkg::SC_RST, sbsa_pkg::LEN_RST, CAP);
        end else if (wr) begin
            r_sc    <= n_sc;
            r_len   <= n_len;
            r_total <= n_total;
        end
    end

    always_comb begin
        if (paddr[2] == REG_SIZE_CLASS) begin
            prdata = sbsa_pkg::APB_W'(r_sc);
        end else begin
            prdata = sbsa_pkg::APB_W'(r_len);
        end
    end

    assign o_cfg.size_class = r_sc;
    assign o_cfg.slot_total = r_total;
    assign o_cfg.load       = wr;
    assign o_cfg.load_total = n_total;

endmodule

@@ rtl/sbsa_word_unit.sv @@
// shared bitmap word unit: first free slot search, bit test, set and take
// depends on sbsa_pkg
module sbsa_word_unit (
    input  logic [sbsa_pkg::WORD_W-1:0] i_word,
    input  logic [sbsa_pkg::POS_W-1:0]  i_pos,
    output logic                        o_any,
    output logic [sbsa_pkg::POS_W-1:0]  o_first,
    output logic                        o_hit,
    output logic [sbsa_pkg::WORD_W-1:0] o_word_set,
    output logic [sbsa_pkg::WORD_W-1:0] o_word_take
);

    localparam logic [sbsa_pkg::WORD_W-1:0] MSB = {1'b1, {(sbsa_pkg::WORD_W-1){1'b0}}};

    logic [sbsa_pkg::WORD_W-1:0] pos_bit;

    // slot 0 sits at the msb, so the highest set bit wins
    always_comb begin
        o_first = '0;
        for (int i = 0; i < sbsa_pkg::WORD_W; i++) begin
            if (i_word[i]) begin
                o_first = sbsa_pkg::POS_W'(sbsa_pkg::WORD_W - 1 - i);
            end
        end
    end

    assign o_any       = |i_word;
    assign pos_bit     = MSB >> i_pos;
    assign o_hit       = |(i_word & pos_bit);
    assign o_word_set  = i_word | pos_bit;
    assign o_word_take = i_word & ~(MSB >> o_first);

endmodule

@@ rtl/sbsa_seq.sv @@
// sequencer, free bitmap, free counter and response register
// depends on sbsa_pkg, sbsa_if and sbsa_word_unit
module sbsa_seq #(
    parameter int MAX_SLOTS = sbsa_pkg::MAX_SLOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sbsa_pkg::t_cfg_bus i_cfg,
    sbsa_req_if.sink           i_req,
    sbsa_rsp_if.source         o_rsp
);

    localparam int MAP_WORDS = (MAX_SLOTS + sbsa_pkg::WORD_W - 1) / sbsa_pkg::WORD_W;
    localparam int WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(MAP_WORDS - 1);
    localparam logic [sbsa_pkg::CNT_W-1:0] RST_TOTAL =
        sbsa_pkg::slot_count(sbsa_pkg::SC_RST, sbsa_pkg::LEN_RST, sbsa_pkg::CNT_W'(MAX_SLOTS));

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FREE, S_DONE} t_state;

    t_state                         r_state;
    logic [sbsa_pkg::WORD_W-1:0]    r_map [MAP_WORDS];
    logic [sbsa_pkg::FREE_W-1:0]    r_count;
    logic                           r_func;
    logic [sbsa_pkg::IDX_W-1:0]     r_idx;
    logic [WIDX_W-1:0]              r_word;
    sbsa_pkg::t_status              r_status;
    logic [sbsa_pkg::IDX_W-1:0]     r_granted;

    logic                           r_out_valid;
    logic [1:0]                     r_out_status;
    logic [sbsa_pkg::IDX_W-1:0]     r_out_index;
    logic [sbsa_pkg::OFS_W-1:0]     r_out_offset;
    logic [sbsa_pkg::FREE_W-1:0]    r_out_free;
    logic                           r_out_full;
    logic                           r_out_all_free;
    logic                           r_out_first;

    logic [WIDX_W-1:0]              sel;
    logic                           u_any;
    logic [sbsa_pkg::POS_W-1:0]     u_first;
    logic                           u_hit;
    logic [sbsa_pkg::WORD_W-1:0]    u_set;
    logic [sbsa_pkg::WORD_W-1:0]    u_take;
    logic [sbsa_pkg::CNT_W-1:0]     cand;
    logic                           scan_hit;
    logic                           out_range;
    logic                           res_ok;

    assign sel = (r_state == S_SCAN) ? r_word : r_idx[sbsa_pkg::POS_W +: WIDX_W];

    sbsa_word_unit u_word (
        .i_word      (r_map[sel]),
        .i_pos       (r_idx[sbsa_pkg::POS_W-1:0]),
        .o_any       (u_any),
        .o_first     (u_first),
        .o_hit       (u_hit),
        .o_word_set  (u_set),
        .o_word_take (u_take)
    );

    assign cand      = sbsa_pkg::CNT_W'({r_word, u_first});
    assign scan_hit  = u_any && (cand < i_cfg.slot_total);
    assign out_range = sbsa_pkg::CNT_W'(r_idx) >= i_cfg.slot_total;
    assign res_ok    = (r_status == sbsa_pkg::ST_OK);

    assign i_req.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= RST_TOTAL[sbsa_pkg::FREE_W-1:0];
            for (int w = 0; w < MAP_WORDS; w++) begin
                r_map[w] <= sbsa_pkg::word_mask(RST_TOTAL, w);
            end
        end else begin
            if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.load) begin
                r_count <= i_cfg.load_total[sbsa_pkg::FREE_W-1:0];
                for (int w = 0; w < MAP_WORDS; w++) begin
                    r_map[w] <= sbsa_pkg::word_mask(i_cfg.load_total, w);
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_func <= i_req.func;
                        r_idx  <= i_req.slot_index;
                        r_word <= '0;
                        if (i_req.func == sbsa_pkg::FUNC_FREE) begin
                            r_state <= S_FREE;
                        end else if (r_count == '0) begin
                            r_status  <= sbsa_pkg::ST_NO_FREE;
                            r_granted <= '0;
                            r_state   <= S_DONE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (scan_hit) begin
                        r_map[sel] <= u_take;
                        r_count    <= r_count - 1'b1;
                        r_granted  <= sbsa_pkg::IDX_W'(cand);
                        r_status   <= sbsa_pkg::ST_OK;
                        r_state    <= S_DONE;
                    end else if (r_word == LAST_WORD) begin
                        r_granted <= '0;
                        r_status  <= sbsa_pkg::ST_NO_FREE;
                        r_state   <= S_DONE;
                    end else begin
                        r_word <= r_word + 1'b1;
                    end
                end
                S_FREE: begin
                    r_granted <= r_idx;
                    r_state   <= S_DONE;
                    if (out_range) begin
                        r_status <= sbsa_pkg::ST_RANGE;
                    end else if (u_hit) begin
                        r_status <= sbsa_pkg::ST_ALREADY;
                    end else begin
                        r_map[sel] <= u_set;
                        r_count    <= r_count + 1'b1;
                        r_status   <= sbsa_pkg::ST_OK;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid    <= 1'b1;
                        r_out_status   <= r_status;
                        r_out_index    <= r_granted;
                        r_out_offset   <= res_ok ?
                            sbsa_pkg::slot_offset(i_cfg.size_class, r_granted) : '0;
                        r_out_free     <= r_count;
                        r_out_full     <= res_ok && (r_func == sbsa_pkg::FUNC_ALLOC)
                                          && (r_count == '0);
                        r_out_all_free <= res_ok && (r_func == sbsa_pkg::FUNC_FREE)
                                          && (sbsa_pkg::CNT_W'(r_count) == i_cfg.slot_total);
                        r_out_first    <= res_ok && (r_func == sbsa_pkg::FUNC_FREE)
                                          && (r_count == sbsa_pkg::FREE_W'(1));
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.status           = r_out_status;
    assign o_rsp.granted_index    = r_out_index;
    assign o_rsp.byte_offset      = r_out_offset;
    assign o_rsp.free_left        = r_out_free;
    assign o_rsp.now_full         = r_out_full;
    assign o_rsp.now_all_free     = r_out_all_free;
    assign o_rsp.first_free_again = r_out_first;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sbsa_pkg::CNT_W'(r_count) <= i_cfg.slot_total)
        else $error("free count above slot count");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> r_state != S_IDLE)
        else $error("request accepted but sequencer idle");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_word <= LAST_WORD)
        else $error("scan ran past last bitmap word");

    a_alloc_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN && scan_hit |=> r_count == $past(r_count) - 1'b1)
        else $error("allocate did not take one slot");
`endif

endmodule

@@ rtl/superblock_bitmap_slot_allocator.sv @@
// top level of the superblock bitmap slot allocator
// depends on sbsa_pkg, sbsa_if, sbsa_cfg and sbsa_seq
//
// One request is worked at a time. A free goes from idle through the free
// and done states; an allocate goes through the scan state, passing over k
// (0 to 3) 32-bit bitmap words before the lowest free slot is found, since
// the single shared word unit scans one word per cycle, and then the done
// state. An allocate with no free slot left goes straight to the done state.
// A finished response waits in an output register, so the next request can
// be accepted while it is pending; while that register is still held by the
// receiver, a later request waits in the done state. A configuration write
// rebuilds the bitmap and free count in the same cycle.
module superblock_bitmap_slot_allocator #(
    parameter int MAX_SLOTS = sbsa_pkg::MAX_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    sbsa_req_if.sink                      i_req,
    sbsa_rsp_if.source                    o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sbsa_pkg::ADDR_W-1:0]   paddr,
    input  logic [sbsa_pkg::APB_W-1:0]    pwdata,
    output logic [sbsa_pkg::APB_W-1:0]    prdata,
    output logic                          pready
);

    sbsa_pkg::t_cfg_bus cfg;

    sbsa_cfg #(.MAX_SLOTS(MAX_SLOTS)) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    sbsa_seq #(.MAX_SLOTS(MAX_SLOTS)) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule

@@ bench/tb_superblock_bitmap_slot_allocator.sv @@
// testbench of the superblock bitmap slot allocator: directed and random alloc/free requests
// checked against a bitmap predictor held in a scoreboard class, under several configurations
// depends on sbsa_pkg, sbsa_if and the rtl top superblock_bitmap_slot_allocator

typedef struct packed {
    sbsa_pkg::t_status status;
    logic [6:0]        granted_index;
    logic [9:0]        byte_offset;
    logic [6:0]        free_left;
    logic              now_full;
    logic              now_all_free;
    logic              first_free_again;
} t_slot_result;

class slot_scoreboard;
    logic [1:0]   size_class;
    logic [6:0]   length_units;
    logic [31:0]  free_map [4];
    logic [6:0]   free_count;
    t_slot_result expected_q [$];
    int           n_requests;
    int           n_checked;
    int           n_mismatch;
    int           status_seen [4];
    int           full_seen;
    int           all_free_seen;
    int           first_free_seen;

    function new();
        size_class   = sbsa_pkg::SC_RST;
        length_units = sbsa_pkg::LEN_RST;
        rebuild_map();
    endfunction

    function int control_bytes();
        case (size_class)
            2'd0:    return 24;
            2'd1:    return 16;
            2'd2:    return 16;
            default: return 32;
        endcase
    endfunction

    function int slot_limit();
        int total;
        int hdr;
        int n;
        total = (int'(length_units) + 1) * 8;
        hdr   = control_bytes();
        if (total <= hdr) return 0;
        n = ((total - hdr) >> 3) / (int'(size_class) + 1);
        if (n > 128) n = 128;
        return n;
    endfunction

    function logic [9:0] offset_bytes(int idx);
        return 10'(control_bytes() + idx * (int'(size_class) + 1) * 8);
    endfunction

    function bit slot_is_free(int idx);
        return free_map[idx / 32][31 - (idx % 32)];
    endfunction

    function void rebuild_map();
        int n;
        n = slot_limit();
        for (int w = 0; w < 4; w++) begin
            if (n >= w * 32 + 32) begin
                free_map[w] = 32'hFFFF_FFFF;
            end else if (n > w * 32) begin
                free_map[w] = ~(32'hFFFF_FFFF >> (n - w * 32));
            end else begin
                free_map[w] = '0;
            end
        end
        free_count = 7'(n);
    endfunction

    function void configure(int reg_idx, logic [31:0] value);
        if (reg_idx == 0) size_class = value[1:0];
        else length_units = value[6:0];
        rebuild_map();
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void note_request(logic func, logic [6:0] idx);
        t_slot_result r;
        int           n;
        int           pick;
        n    = slot_limit();
        r    = '0;
        r.status = sbsa_pkg::ST_OK;
        pick = -1;
        if (func == sbsa_pkg::FUNC_ALLOC) begin
            if (free_count != 0) begin
                for (int i = 0; i < n && pick < 0; i++) begin
                    if (slot_is_free(i)) pick = i;
                end
            end
            if (pick >= 0) begin
                free_map[pick / 32][31 - (pick % 32)] = 1'b0;
                free_count      = free_count - 7'd1;
                r.granted_index = 7'(pick);
                r.byte_offset   = offset_bytes(pick);
                r.now_full      = (free_count == 0);
            end else begin
                r.status = sbsa_pkg::ST_NO_FREE;
            end
        end else begin
            r.granted_index = idx;
            if (int'(idx) >= n) begin
                r.status = sbsa_pkg::ST_RANGE;
            end else if (slot_is_free(idx)) begin
                r.status = sbsa_pkg::ST_ALREADY;
            end else begin
                free_map[idx / 32][31 - (idx % 32)] = 1'b1;
                free_count         = free_count + 7'd1;
                r.byte_offset      = offset_bytes(idx);
                r.now_all_free     = (int'(free_count) == n);
                r.first_free_again = (free_count == 1);
            end
        end
        r.free_left = free_count;
        n_requests++;
        status_seen[r.status]++;
        full_seen       += r.now_full;
        all_free_seen   += r.now_all_free;
        first_free_seen += r.first_free_again;
        expected_q.push_back(r);
    endfunction

    function string show(t_slot_result r);
        return $sformatf("status=%0d idx=%0d ofs=%0d left=%0d full=%0b all=%0b first=%0b",
                         r.status, r.granted_index, r.byte_offset, r.free_left,
                         r.now_full, r.now_all_free, r.first_free_again);
    endfunction

    function void check_response(t_slot_result got);
        t_slot_result exp_r;
        if (expected_q.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= 10) $display("unexpected response: %s", show(got));
            return;
        end
        exp_r = expected_q.pop_front();
        n_checked++;
        if (got.status !== exp_r.status || got.granted_index !== exp_r.granted_index ||
            got.byte_offset !== exp_r.byte_offset || got.free_left !== exp_r.free_left ||
            got.now_full !== exp_r.now_full || got.now_all_free !== exp_r.now_all_free ||
            got.first_free_again !== exp_r.first_free_again) begin
            n_mismatch++;
            if (n_mismatch <= 10) begin
                $display("mismatch on response %0d\n  expected %s\n  actual   %s",
                         n_checked, show(exp_r), show(got));
            end
        end
    endfunction
endclass

module tb_superblock_bitmap_slot_allocator;

    localparam int REG_SIZE_CLASS   = 0;
    localparam int REG_LENGTH_UNITS = 1;
    localparam int N_PHASES         = 12;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [sbsa_pkg::ADDR_W-1:0]  paddr;
    logic [sbsa_pkg::APB_W-1:0]   pwdata;
    logic [sbsa_pkg::APB_W-1:0]   prdata;
    logic                         pready;

    sbsa_req_if req_ch ();
    sbsa_rsp_if rsp_ch ();

    slot_scoreboard sb;
    int             send_idle_pct;
    int             recv_stall_pct;
    bit             filling;
    int             n_configs;

    superblock_bitmap_slot_allocator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin : rsp_monitor
        t_slot_result got;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got.status           = sbsa_pkg::t_status'(rsp_ch.status);
            got.granted_index    = rsp_ch.granted_index;
            got.byte_offset      = rsp_ch.byte_offset;
            got.free_left        = rsp_ch.free_left;
            got.now_full         = rsp_ch.now_full;
            got.now_all_free     = rsp_ch.now_all_free;
            got.first_free_again = rsp_ch.first_free_again;
            sb.check_response(got);
        end
    end

    task automatic send_request(logic func, logic [sbsa_pkg::IDX_W-1:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.func       <= func;
        req_ch.slot_index <= idx;
        do @(posedge i_clk); while (!req_ch.ready);
        sb.note_request(func, idx);
    endtask

    task automatic write_register(int reg_idx, logic [sbsa_pkg::APB_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= sbsa_pkg::ADDR_W'(reg_idx * 4);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.configure(reg_idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic reconfigure(int sc, int len);
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        write_register(REG_SIZE_CLASS, sbsa_pkg::APB_W'(sc));
        @(posedge i_clk);
        write_register(REG_LENGTH_UNITS, sbsa_pkg::APB_W'(len));
        n_configs++;
    endtask

    function automatic logic [sbsa_pkg::IDX_W-1:0] free_target(int n);
        int r;
        int start;
        r = $urandom_range(99);
        if (n == 0 || r < 14) begin
            return (r < 6) ? sbsa_pkg::IDX_W'(n) : sbsa_pkg::IDX_W'($urandom_range(127));
        end
        start = $urandom_range(n - 1);
        if (r < 24) return sbsa_pkg::IDX_W'(start);
        for (int j = 0; j < n; j++) begin
            if (!sb.slot_is_free((start + j) % n)) return sbsa_pkg::IDX_W'((start + j) % n);
        end
        return sbsa_pkg::IDX_W'(start);
    endfunction

    task automatic random_requests(int count);
        int n;
        for (int k = 0; k < count; k++) begin
            n = sb.slot_limit();
            if (sb.free_count == 0) filling = 1'b0;
            else if (int'(sb.free_count) == n) filling = 1'b1;
            if ($urandom_range(99) < 6) begin
                send_request(1'($urandom_range(1)), sbsa_pkg::IDX_W'($urandom_range(127)));
            end else if ($urandom_range(99) < (filling ? 80 : 20)) begin
                send_request(sbsa_pkg::FUNC_ALLOC, sbsa_pkg::IDX_W'($urandom_range(127)));
            end else begin
                send_request(sbsa_pkg::FUNC_FREE, free_target(n));
            end
        end
    endtask

    initial begin
        int sc_tab  [10] = '{0, 3, 1, 2, 3, 0, 2, 1, 0, 3};
        int len_tab [10] = '{127, 127, 127, 127, 3, 3, 20, 0, 60, 7};
        int sc;
        int len;
        int guard;

        sb             = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        filling        = 1'b1;
        n_configs      = 0;
        i_rst_n           <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.func       <= sbsa_pkg::FUNC_ALLOC;
        req_ch.slot_index <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset configuration: first slots, double free, out of range
        send_request(sbsa_pkg::FUNC_ALLOC, 7'd127);
        send_request(sbsa_pkg::FUNC_ALLOC, 7'd0);
        send_request(sbsa_pkg::FUNC_FREE, 7'd0);
        send_request(sbsa_pkg::FUNC_FREE, 7'd0);
        send_request(sbsa_pkg::FUNC_FREE, 7'd125);
        send_request(sbsa_pkg::FUNC_FREE, 7'd127);
        send_request(sbsa_pkg::FUNC_FREE, 7'd124);
        send_request(sbsa_pkg::FUNC_ALLOC, 7'd85);
        send_request(sbsa_pkg::FUNC_FREE, 7'd1);
        // length too short for any slot
        reconfigure(3, 3);
        send_request(sbsa_pkg::FUNC_ALLOC, 7'd42);
        send_request(sbsa_pkg::FUNC_FREE, 7'd0);
        // single slot superblock
        reconfigure(0, 3);
        send_request(sbsa_pkg::FUNC_ALLOC, 7'd0);
        send_request(sbsa_pkg::FUNC_ALLOC, 7'd0);
        send_request(sbsa_pkg::FUNC_FREE, 7'd1);
        send_request(sbsa_pkg::FUNC_FREE, 7'd0);
        send_request(sbsa_pkg::FUNC_FREE, 7'd0);

        for (int p = 0; p < N_PHASES; p++) begin
            if (p < 10) begin
                sc  = sc_tab[p];
                len = len_tab[p];
            end else begin
                sc  = $urandom_range(3);
                len = $urandom_range(127);
            end
            reconfigure(sc, len);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            filling = 1'b1;
            random_requests(80 + 2 * sb.slot_limit());
        end

        req_ch.valid   <= 1'b0;
        recv_stall_pct = 0;
        guard = 0;
        while (sb.pending() != 0 && guard < 10000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0d responses never arrived", sb.pending());
            sb.n_mismatch += sb.pending();
        end

        $display("%0d requests over %0d configurations, %0d responses checked, %0d mismatches",
                 sb.n_requests, n_configs + 1, sb.n_checked, sb.n_mismatch);
        $display("status ok/no-free/range/already %0d/%0d/%0d/%0d, %s %0d, %s %0d, %s %0d",
                 sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3],
                 "full", sb.full_seen, "all-free", sb.all_free_seen,
                 "first-free", sb.first_free_seen);
        if (sb.n_mismatch == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

@@ superblock_bitmap_slot_allocator.f @@
rtl/sbsa_pkg.sv
rtl/sbsa_if.sv
rtl/sbsa_cfg.sv
rtl/sbsa_word_unit.sv
rtl/sbsa_seq.sv
rtl/superblock_bitmap_slot_allocator.sv
bench/tb_superblock_bitmap_slot_allocator.sv
